// File: design/fisqrt_pkg.sv
package fisqrt_pkg;

    localparam logic [31:0] C_MAGIC    = 32'h5F37_59DF;
    localparam logic [31:0] C_HALF     = 32'h3F00_0000;
    localparam logic [31:0] C_ONE_HALF = 32'h3FC0_0000;
    localparam logic [31:0] C_QNAN     = 32'hFFC0_0000;
    localparam logic [31:0] C_QBIT     = 32'h0040_0000;
    localparam logic [30:0] C_INF_MAG  = 31'h7F80_0000;
    localparam int          C_DEPTH    = 16;
    localparam int          C_G_TAPS   = 13;

    // Unrounded result: value = sig * 2^(exp - 127 - 47) unless flagged special or zero.
    typedef struct packed {
        logic               spec;
        logic [31:0]        spec_word;
        logic               zero;
        logic               sign;
        logic signed [10:0] exp;
        logic [47:0]        sig;
    } t_unr;

    // Operands of an addition after swap and alignment.
    typedef struct packed {
        logic        spec;
        logic [31:0] spec_word;
        logic        sign;
        logic        sub;
        logic [7:0]  exp_big;
        logic [26:0] big;
        logic [26:0] minor;
    } t_aln;

    function automatic logic f_is_nan(input logic [31:0] a);
        return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    endfunction

    function automatic logic f_is_inf(input logic [31:0] a);
        return (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    endfunction

    function automatic logic f_is_zero(input logic [31:0] a);
        return a[30:0] == 31'd0;
    endfunction

    function automatic logic [7:0] f_eff_exp(input logic [31:0] a);
        return (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    endfunction

    function automatic t_unr f_mul(input logic [31:0] a, input logic [31:0] b);
        t_unr       u;
        logic [23:0] ma;
        logic [23:0] mb;
        ma = {a[30:23] != 8'd0, a[22:0]};
        mb = {b[30:23] != 8'd0, b[22:0]};
        u.sign      = a[31] ^ b[31];
        u.exp       = $signed({3'b0, f_eff_exp(a)}) + $signed({3'b0, f_eff_exp(b)})
                      - 11'sd126;
        u.sig       = ma * mb;
        u.zero      = 1'b0;
        u.spec      = 1'b1;
        u.spec_word = 32'd0;
        if (f_is_nan(a)) begin
            u.spec_word = a | C_QBIT;
        end else if (f_is_nan(b)) begin
            u.spec_word = b | C_QBIT;
        end else if ((f_is_inf(a) && f_is_zero(b)) || (f_is_zero(a) && f_is_inf(b))) begin
            u.spec_word = C_QNAN;
        end else if (f_is_inf(a) || f_is_inf(b)) begin
            u.spec_word = {u.sign, C_INF_MAG};
        end else begin
            u.spec = 1'b0;
        end
        return u;
    endfunction

    // Computes a - b up to the aligned significands.
    function automatic t_aln f_align(input logic [31:0] a, input logic [31:0] b);
        t_aln        al;
        logic [31:0] bn;
        logic [31:0] hi;
        logic [31:0] lo;
        logic [7:0]  d;
        logic [26:0] msm;
        logic [26:0] sh;
        logic        lost;
        bn = {~b[31], b[30:0]};
        if (a[30:0] >= bn[30:0]) begin
            hi = a;
            lo = bn;
        end else begin
            hi = bn;
            lo = a;
        end
        al.sign    = hi[31];
        al.sub     = a[31] ^ bn[31];
        al.exp_big = f_eff_exp(hi);
        al.big     = {hi[30:23] != 8'd0, hi[22:0], 3'b000};
        msm        = {lo[30:23] != 8'd0, lo[22:0], 3'b000};
        d          = al.exp_big - f_eff_exp(lo);
        if (d >= 8'd27) begin
            al.minor = {26'd0, msm != 27'd0};
        end else begin
            sh       = msm >> d[4:0];
            lost     = (msm & ~(27'h7FF_FFFF << d[4:0])) != 27'd0;
            al.minor = sh | {26'd0, lost};
        end
        al.spec      = 1'b1;
        al.spec_word = 32'd0;
        if (f_is_nan(a)) begin
            al.spec_word = a | C_QBIT;
        end else if (f_is_nan(b)) begin
            al.spec_word = b | C_QBIT;
        end else if (f_is_inf(a) && f_is_inf(bn) && (a[31] != bn[31])) begin
            al.spec_word = C_QNAN;
        end else if (f_is_inf(a)) begin
            al.spec_word = a;
        end else if (f_is_inf(bn)) begin
            al.spec_word = bn;
        end else begin
            al.spec = 1'b0;
        end
        return al;
    endfunction

    function automatic t_unr f_sum(input t_aln al);
        t_unr        u;
        logic [27:0] s;
        if (al.sub) begin
            s = {1'b0, al.big} - {1'b0, al.minor};
        end else begin
            s = {1'b0, al.big} + {1'b0, al.minor};
        end
        u.spec      = al.spec;
        u.spec_word = al.spec_word;
        u.zero      = 1'b0;
        u.sign      = (al.sub && (s == 28'd0)) ? 1'b0 : al.sign;
        u.exp       = $signed({3'b0, al.exp_big}) + 11'sd1;
        u.sig       = {s, 20'd0};
        return u;
    endfunction

    // Moves the leading one to the top bit.
    function automatic t_unr f_norm(input t_unr u);
        t_unr        v;
        logic [47:0] s;
        logic [5:0]  lz;
        v  = u;
        s  = u.sig;
        lz = 6'd0;
        if (s[47:16] == 32'd0) begin
            s  = s << 32;
            lz = lz + 6'd32;
        end
        if (s[47:32] == 16'd0) begin
            s  = s << 16;
            lz = lz + 6'd16;
        end
        if (s[47:40] == 8'd0) begin
            s  = s << 8;
            lz = lz + 6'd8;
        end
        if (s[47:44] == 4'd0) begin
            s  = s << 4;
            lz = lz + 6'd4;
        end
        if (s[47:46] == 2'd0) begin
            s  = s << 2;
            lz = lz + 6'd2;
        end
        if (!s[47]) begin
            s  = s << 1;
            lz = lz + 6'd1;
        end
        v.sig  = s;
        v.exp  = u.exp - $signed({5'b0, lz});
        v.zero = (u.sig == 48'd0);
        return v;
    endfunction

    // Round to nearest even, with gradual underflow and overflow to infinity.
    function automatic logic [31:0] f_round(input t_unr u);
        logic [30:0] w;
        logic        g;
        logic        st;
        logic        lost;
        logic [10:0] sh;
        logic [47:0] t;
        if (u.spec) begin
            return u.spec_word;
        end
        if (u.zero) begin
            return {u.sign, 31'd0};
        end
        if (u.exp > 11'sd254) begin
            return {u.sign, C_INF_MAG};
        end
        if (u.exp >= 11'sd1) begin
            w  = {u.exp[7:0], u.sig[46:24]};
            g  = u.sig[23];
            st = u.sig[22:0] != 23'd0;
        end else begin
            sh = 11'(11'sd1 - u.exp);
            if (sh >= 11'd26) begin
                w  = 31'd0;
                g  = 1'b0;
                st = 1'b1;
            end else begin
                t    = u.sig >> sh[4:0];
                lost = (u.sig & ~(48'hFFFF_FFFF_FFFF << sh[4:0])) != 48'd0;
                w    = {8'd0, t[46:24]};
                g    = t[23];
                st   = (t[22:0] != 23'd0) || lost;
            end
        end
        w = w + {30'd0, g & (st | w[0])};
        return {u.sign, w};
    endfunction

endpackage

// File: design/fast_inverse_sqrt_float32_top.sv
// Fast inverse square-root estimate on binary32 words.
// Input channel (i_s_*): one item carries the raw bit pattern of x in tdata.
// Output channel (o_m_*): one item carries the bit pattern of the estimate
// g * (1.5 - (0.5*x*g)*g), where g is the magic-constant first guess.
// Every float step rounds to nearest even and handles subnormals, infinities
// and NaNs as IEEE arithmetic does.
// The pipeline takes one item per clock while the receiver does not stall
// it: four binary32 multiplies of three stages each (multiply, normalize,
// round) and one subtract of four stages (align, add, normalize, round) run
// in sequence.
// A synchronous active-low reset clears the valid bits; data is not reset.
// When the receiver holds i_m_tready low while an output item is waiting,
// the whole pipeline freezes and o_s_tready drops, so nothing is lost or
// repeated. While the output stage is empty the pipeline keeps advancing.
module fast_inverse_sqrt_float32_top
    import fisqrt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [31:0] operand_bits
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata    // [31:0] result_bits
);

    logic               w_en;
    logic [C_DEPTH-1:0] r_vld;
    logic [C_DEPTH-1:0] n_vld;
    logic [31:0]        r_g [C_G_TAPS];
    logic [31:0]        n_guess;

    // Stage registers, named by the value they build.
    t_unr        r_h_m, r_h_n;
    logic [31:0] r_h;
    t_unr        r_p1_m, r_p1_n;
    logic [31:0] r_p1;
    t_unr        r_p2_m, r_p2_n;
    logic [31:0] r_p2;
    t_aln        r_c_a;
    t_unr        r_c_s, r_c_n;
    logic [31:0] r_c;
    t_unr        r_r_m, r_r_n;
    logic [31:0] r_r;

    // The pipeline advances unless a finished item is waiting on the receiver.
    assign w_en       = !r_vld[C_DEPTH-1] || i_m_tready;
    assign o_s_tready = w_en;
    assign o_m_tvalid = r_vld[C_DEPTH-1];
    assign o_m_tdata  = r_r;

    // First guess: arithmetic shift right by one, then a wrapping subtract.
    assign n_guess = C_MAGIC - {i_s_tdata[31], i_s_tdata[31:1]};
    assign n_vld   = {r_vld[C_DEPTH-2:0], i_s_tvalid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_g[0] <= n_guess;
            for (int k = 1; k < C_G_TAPS; k++) begin
                r_g[k] <= r_g[k-1];
            end
            // h = 0.5 * x
            r_h_m  <= f_mul(C_HALF, i_s_tdata);
            r_h_n  <= f_norm(r_h_m);
            r_h    <= f_round(r_h_n);
            // p1 = h * g
            r_p1_m <= f_mul(r_h, r_g[2]);
            r_p1_n <= f_norm(r_p1_m);
            r_p1   <= f_round(r_p1_n);
            // p2 = p1 * g
            r_p2_m <= f_mul(r_p1, r_g[5]);
            r_p2_n <= f_norm(r_p2_m);
            r_p2   <= f_round(r_p2_n);
            // corr = 1.5 - p2
            r_c_a  <= f_align(C_ONE_HALF, r_p2);
            r_c_s  <= f_sum(r_c_a);
            r_c_n  <= f_norm(r_c_s);
            r_c    <= f_round(r_c_n);
            // result = g * corr
            r_r_m  <= f_mul(r_g[12], r_c);
            r_r_n  <= f_norm(r_r_m);
            r_r    <= f_round(r_r_n);
        end
    end

endmodule
